/* design/shfc_pkg.sv */
// Package: phase codes, frame constants, state and result types for the frame checker.
`timescale 1ns / 1ps
`default_nettype none

package shfc_pkg;

  // Frame bytes and status codes
  localparam logic [7:0] SYNC_BYTE  = 8'hAA;
  localparam logic [7:0] HEAD2_BYTE = 8'h75;
  localparam logic [7:0] ERR_STATUS = 8'h7F;

  // Command ranges: below CMD_LOW_LIMIT, or strictly inside either window
  localparam logic [7:0] CMD_LOW_LIMIT = 8'h16;
  localparam logic [7:0] CMD_A_LO      = 8'h81;
  localparam logic [7:0] CMD_A_HI      = 8'h85;
  localparam logic [7:0] CMD_B_LO      = 8'hC1;
  localparam logic [7:0] CMD_B_HI      = 8'hC5;

  // Parse phases
  localparam logic [2:0] PH_SYNC  = 3'd0;
  localparam logic [2:0] PH_HEAD2 = 3'd1;
  localparam logic [2:0] PH_CMD   = 3'd2;
  localparam logic [2:0] PH_LENHI = 3'd3;
  localparam logic [2:0] PH_LENLO = 3'd4;
  localparam logic [2:0] PH_RSV   = 3'd5;
  localparam logic [2:0] PH_DATA  = 3'd6;
  localparam logic [2:0] PH_CSUM  = 3'd7;

  // Parser state carried from byte to byte
  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] remaining_length;
    logic [7:0]  running_xor;
    logic [7:0]  frame_status;
  } parse_state_t;

  // One result item
  typedef struct packed {
    logic       frame_good;
    logic       frame_error;
    logic [7:0] status_code;
    logic [2:0] parse_phase;
  } parse_result_t;

  // Valid command byte check
  function automatic logic cmd_ok(input logic [7:0] c);
    cmd_ok = (c < CMD_LOW_LIMIT) ||
             ((c > CMD_A_LO) && (c < CMD_A_HI)) ||
             ((c > CMD_B_LO) && (c < CMD_B_HI));
  endfunction

endpackage

`default_nettype wire

/* design/shfc_in_if.sv */
// Interface: input channel carrying one received byte per item.
`timescale 1ns / 1ps
`default_nettype none

interface shfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* design/shfc_out_if.sv */
// Interface: result channel carrying frame flags, status and phase per item.
`timescale 1ns / 1ps
`default_nettype none

interface shfc_out_if;
  logic       valid;
  logic       ready;
  logic       frame_good;
  logic       frame_error;
  logic [7:0] status_code;
  logic [2:0] parse_phase;

  modport source (output valid, output frame_good, output frame_error,
                  output status_code, output parse_phase, input ready);
  modport sink   (input valid, input frame_good, input frame_error,
                  input status_code, input parse_phase, output ready);
endinterface

`default_nettype wire

/* design/shfc_step.sv */
// Next-state and result logic of the frame parser for one byte.
`timescale 1ns / 1ps
`default_nettype none

module shfc_step (
  input  shfc_pkg::parse_state_t  cur,
  input  logic [7:0]              rx_byte,
  output shfc_pkg::parse_state_t  nxt,
  output shfc_pkg::parse_result_t res
);
  import shfc_pkg::*;

  logic [7:0]  xor_acc;
  logic [15:0] len_dec;
  logic        good;
  logic        err;

  assign xor_acc = cur.running_xor ^ rx_byte;
  // Data countdown saturates at zero
  assign len_dec = (cur.remaining_length != 16'd0) ? (cur.remaining_length - 16'd1)
                                                    : 16'd0;

  // Phase decode
  always_comb begin
    nxt = cur;
    nxt.running_xor = xor_acc;
    good = 1'b0;
    err  = 1'b0;
    unique case (cur.phase)
      PH_SYNC: begin
        if (rx_byte == SYNC_BYTE) begin
          nxt.running_xor = rx_byte;
          nxt.phase       = PH_HEAD2;
        end else begin
          nxt.frame_status = ERR_STATUS;
          err = 1'b1;
        end
      end
      PH_HEAD2: begin
        if (rx_byte == HEAD2_BYTE) begin
          nxt.phase = PH_CMD;
        end else begin
          nxt.frame_status = ERR_STATUS;
          nxt.phase        = PH_SYNC;
          err = 1'b1;
        end
      end
      PH_CMD: begin
        if (cmd_ok(rx_byte)) begin
          nxt.phase = PH_LENHI;
        end else begin
          nxt.frame_status = ERR_STATUS;
          nxt.phase        = PH_SYNC;
          err = 1'b1;
        end
      end
      PH_LENHI: begin
        nxt.remaining_length = {8'd0, rx_byte};
        nxt.phase            = PH_LENLO;
      end
      PH_LENLO: begin
        nxt.remaining_length = {cur.remaining_length[7:0], rx_byte};
        nxt.phase            = PH_RSV;
      end
      PH_RSV: begin
        nxt.phase = (cur.remaining_length != 16'd0) ? PH_DATA : PH_CSUM;
      end
      PH_DATA: begin
        nxt.remaining_length = len_dec;
        if (len_dec == 16'd0) begin
          nxt.phase = PH_CSUM;
        end
      end
      PH_CSUM: begin
        if (xor_acc == 8'd0) begin
          nxt.frame_status = cur.frame_status + 8'd1;
          good = 1'b1;
        end else begin
          nxt.frame_status = ERR_STATUS;
          err = 1'b1;
        end
        nxt.phase = PH_SYNC;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  // Result item follows the updated state
  always_comb begin
    res.frame_good  = good;
    res.frame_error = err;
    res.status_code = nxt.frame_status;
    res.parse_phase = nxt.phase;
  end

endmodule

`default_nettype wire

/* design/sync_header_frame_checker.sv */
// Top level: sync-header frame checker with input register and result register.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------------------
//   in_ch    | in  | rx_byte[7:0]
//   out_ch   | out | frame_good, frame_error, status_code[7:0], parse_phase[2:0]
//
// One byte per clock sustained while out_ch.ready stays high; a byte passes from the
// input register through the parser logic into the result register.
// The parser state updates as a byte moves from the input register to the
// result register, so each byte sees the state left by the one before.
// Synchronous reset clears the parser state and both valid flags.
// A stalled result holds the input register; in_ch.ready drops only when
// both registers are full and out_ch.ready is low.
`timescale 1ns / 1ps
`default_nettype none

module sync_header_frame_checker (
  input  logic          clk,
  input  logic          rst,
  shfc_in_if.sink       in_ch,
  shfc_out_if.source    out_ch
);
  import shfc_pkg::*;

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_adv;
  logic          out_valid;
  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t res_next;
  parse_result_t res;

  // Handshake
  assign s1_adv      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.rx_byte;
    end
  end

  // Parser logic
  shfc_step u_step (
    .cur     (state),
    .rx_byte (s1_byte),
    .nxt     (state_next),
    .res     (res_next)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_adv || (out_valid && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res <= res_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.frame_good  = res.frame_good;
  assign out_ch.frame_error = res.frame_error;
  assign out_ch.status_code = res.status_code;
  assign out_ch.parse_phase = res.parse_phase;

`ifndef SYNTH
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res.frame_good && res.frame_error))
    else $error("good and error flagged together");

  a_error_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.frame_error) |-> (res.status_code == ERR_STATUS))
    else $error("error result without error status");

  a_good_resync: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.frame_good) |-> (res.parse_phase == PH_SYNC))
    else $error("good frame did not return to sync hunt");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> (state == $past(state)))
    else $error("parser state moved without a byte");
`endif

endmodule

`default_nettype wire

/* bench/tb_sync_header_frame_checker.sv */
// Testbench for the sync-header frame checker: directed byte table plus random frames.
`timescale 1ns / 1ps

module tb_sync_header_frame_checker;
  import shfc_pkg::*;

  localparam int HOLD_CYCLES    = 400;   // long receiver hold to fill the block
  localparam int IDLE_LIMIT     = 4000;  // cycles with no accepted item before giving up
  localparam int RANDOM_ITEMS   = 775;
  localparam int DIRECTED_ROWS  = 25;

  // Command bytes on either side of every window boundary
  localparam logic [7:0] CMD_OK_EDGES[6]  = '{8'h00, 8'h15, 8'h82, 8'h84, 8'hC2, 8'hC4};
  localparam logic [7:0] CMD_BAD_EDGES[6] = '{8'h16, 8'h81, 8'h85, 8'hC1, 8'hC5, 8'hFF};

  // One row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    parse_result_t want;
  } directed_row_t;

  localparam parse_result_t FROM_MODEL = '0;

  localparam directed_row_t DIRECTED[DIRECTED_ROWS] = '{
    // hunting: non-sync bytes at both extremes, then sync
    '{8'h00,      1'b1, '{1'b0, 1'b1, ERR_STATUS, PH_SYNC}},
    '{8'hFF,      1'b1, '{1'b0, 1'b1, ERR_STATUS, PH_SYNC}},
    '{SYNC_BYTE,  1'b1, '{1'b0, 1'b0, ERR_STATUS, PH_HEAD2}},
    // bad second header
    '{8'h74,      1'b1, '{1'b0, 1'b1, ERR_STATUS, PH_SYNC}},
    '{SYNC_BYTE,  1'b1, '{1'b0, 1'b0, ERR_STATUS, PH_HEAD2}},
    '{HEAD2_BYTE, 1'b1, '{1'b0, 1'b0, ERR_STATUS, PH_CMD}},
    // command just above the low range
    '{8'h16,      1'b1, '{1'b0, 1'b1, ERR_STATUS, PH_SYNC}},
    // zero-length frame, good checksum, status counts up from 0x7F
    '{SYNC_BYTE,  1'b1, '{1'b0, 1'b0, ERR_STATUS, PH_HEAD2}},
    '{HEAD2_BYTE, 1'b1, '{1'b0, 1'b0, ERR_STATUS, PH_CMD}},
    '{8'h15,      1'b1, '{1'b0, 1'b0, ERR_STATUS, PH_LENHI}},
    '{8'h00,      1'b0, FROM_MODEL},
    '{8'h00,      1'b0, FROM_MODEL},
    '{8'h00,      1'b0, FROM_MODEL},
    '{8'hCA,      1'b1, '{1'b1, 1'b0, 8'h80, PH_SYNC}},
    // one data byte, wrong checksum
    '{SYNC_BYTE,  1'b1, '{1'b0, 1'b0, 8'h80, PH_HEAD2}},
    '{HEAD2_BYTE, 1'b1, '{1'b0, 1'b0, 8'h80, PH_CMD}},
    '{8'hC4,      1'b0, FROM_MODEL},
    '{8'h00,      1'b0, FROM_MODEL},
    '{8'h01,      1'b0, FROM_MODEL},
    '{8'hFF,      1'b0, FROM_MODEL},
    '{8'h5A,      1'b0, FROM_MODEL},
    '{8'h00,      1'b1, '{1'b0, 1'b1, ERR_STATUS, PH_SYNC}},
    // command just below the first window
    '{SYNC_BYTE,  1'b1, '{1'b0, 1'b0, ERR_STATUS, PH_HEAD2}},
    '{HEAD2_BYTE, 1'b1, '{1'b0, 1'b0, ERR_STATUS, PH_CMD}},
    '{8'h81,      1'b1, '{1'b0, 1'b1, ERR_STATUS, PH_SYNC}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  shfc_in_if  in_ch ();
  shfc_out_if out_ch ();

  sync_header_frame_checker i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  parse_state_t  frame_track;     // predicted parser state
  parse_result_t status_due[$];   // predicted results not yet seen
  logic [7:0]    frame_bytes[$];  // bytes of the frame being sent
  int            error_count  = 0;
  int            result_index = 0;
  int            in_burst     = 0;
  int            out_burst    = 0;
  int            idle_cycles  = 0;
  bit            hold_req     = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Wait before an item: mostly random, sometimes a run of back-to-back items
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Advance the predicted parser by one byte and return the result it gives
  function automatic parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t r;
    logic          cmd_valid;
    r = '0;
    cmd_valid = (b < CMD_LOW_LIMIT) ||
                (b inside {[CMD_A_LO + 8'd1 : CMD_A_HI - 8'd1]}) ||
                (b inside {[CMD_B_LO + 8'd1 : CMD_B_HI - 8'd1]});
    frame_track.running_xor = frame_track.running_xor ^ b;
    case (frame_track.phase)
      PH_SYNC: begin
        if (b == SYNC_BYTE) begin
          frame_track.running_xor = b;
          frame_track.phase       = PH_HEAD2;
        end else begin
          frame_track.frame_status = ERR_STATUS;
          r.frame_error            = 1'b1;
        end
      end
      PH_HEAD2: begin
        if (b == HEAD2_BYTE) begin
          frame_track.phase = PH_CMD;
        end else begin
          frame_track.frame_status = ERR_STATUS;
          frame_track.phase        = PH_SYNC;
          r.frame_error            = 1'b1;
        end
      end
      PH_CMD: begin
        if (cmd_valid) begin
          frame_track.phase = PH_LENHI;
        end else begin
          frame_track.frame_status = ERR_STATUS;
          frame_track.phase        = PH_SYNC;
          r.frame_error            = 1'b1;
        end
      end
      PH_LENHI: begin
        frame_track.remaining_length = {8'h00, b};
        frame_track.phase            = PH_LENLO;
      end
      PH_LENLO: begin
        frame_track.remaining_length = {frame_track.remaining_length[7:0], b};
        frame_track.phase            = PH_RSV;
      end
      PH_RSV: begin
        frame_track.phase = (frame_track.remaining_length != 16'd0) ? PH_DATA : PH_CSUM;
      end
      PH_DATA: begin
        if (frame_track.remaining_length != 16'd0)
          frame_track.remaining_length = frame_track.remaining_length - 16'd1;
        if (frame_track.remaining_length == 16'd0)
          frame_track.phase = PH_CSUM;
      end
      default: begin
        // checksum byte: total over the whole frame must be zero
        if (frame_track.running_xor == 8'h00) begin
          frame_track.frame_status = frame_track.frame_status + 8'd1;
          r.frame_good             = 1'b1;
        end else begin
          frame_track.frame_status = ERR_STATUS;
          r.frame_error            = 1'b1;
        end
        frame_track.phase = PH_SYNC;
      end
    endcase
    r.status_code = frame_track.frame_status;
    r.parse_phase = frame_track.phase;
    return r;
  endfunction

  // Offer one byte, wait for it to be taken, then queue what it should produce
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input parse_result_t typed_want);
    int            gap;
    parse_result_t predicted;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predicted = parse_byte(b);
    status_due.push_back(typed ? typed_want : predicted);
  endtask

  function automatic logic [7:0] pick_command(input bit want_valid);
    if (want_valid) begin
      case ($urandom_range(0, 3))
        0:       return 8'($urandom_range(0, CMD_LOW_LIMIT - 1));
        1:       return 8'($urandom_range(CMD_A_LO + 1, CMD_A_HI - 1));
        2:       return 8'($urandom_range(CMD_B_LO + 1, CMD_B_HI - 1));
        default: return CMD_OK_EDGES[$urandom_range(0, 5)];
      endcase
    end
    if ($urandom_range(0, 1) == 0)
      return CMD_BAD_EDGES[$urandom_range(0, 5)];
    return 8'($urandom);
  endfunction

  // Build one frame (mostly well formed, some noise and broken ones) and send it
  task automatic send_random_frame(output int sent);
    int         kind;
    int         len;
    logic [7:0] sum;
    kind = $urandom_range(0, 99);
    frame_bytes.delete();
    if (kind < 8) begin
      // line noise while hunting
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
    end else begin
      frame_bytes.push_back(SYNC_BYTE);
      if (kind < 12) begin
        frame_bytes.push_back(8'($urandom));
      end else begin
        frame_bytes.push_back(HEAD2_BYTE);
        if (kind < 18) begin
          frame_bytes.push_back(pick_command(1'b0));
        end else begin
          frame_bytes.push_back(pick_command(1'b1));
          if ($urandom_range(0, 29) == 0)
            len = $urandom_range(200, 300);
          else
            len = $urandom_range(0, 8);
          frame_bytes.push_back(8'(len >> 8));
          frame_bytes.push_back(8'(len));
          frame_bytes.push_back(8'($urandom));
          repeat (len) frame_bytes.push_back(8'($urandom));
          sum = 8'h00;
          foreach (frame_bytes[k]) sum = sum ^ frame_bytes[k];
          // a few frames get a corrupted checksum
          if (kind < 26)
            sum = sum ^ 8'($urandom_range(1, 255));
          frame_bytes.push_back(sum);
        end
      end
    end
    sent = frame_bytes.size();
    while (frame_bytes.size() > 0)
      send_byte(frame_bytes.pop_front(), 1'b0, FROM_MODEL);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR result %0d: %s", result_index, msg);
    error_count++;
  endtask

  // Receiver: random stalls per item, plus one long hold on request
  initial begin : receiver
    int stall;
    out_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = draw_wait(out_burst);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin : compare_results
    parse_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (status_due.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = status_due.pop_front();
        if (out_ch.frame_good !== want.frame_good)
          report_mismatch($sformatf("frame_good %0b, expected %0b",
                                    out_ch.frame_good, want.frame_good));
        if (out_ch.frame_error !== want.frame_error)
          report_mismatch($sformatf("frame_error %0b, expected %0b",
                                    out_ch.frame_error, want.frame_error));
        if (out_ch.status_code !== want.status_code)
          report_mismatch($sformatf("status_code %02h, expected %02h",
                                    out_ch.status_code, want.status_code));
        if (out_ch.parse_phase !== want.parse_phase)
          report_mismatch($sformatf("parse_phase %0d, expected %0d",
                                    out_ch.parse_phase, want.parse_phase));
      end
      result_index++;
    end
  end

  // Watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus: reset, directed table, random frames
  initial begin : stimulus
    int sent;
    int total;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    frame_track   = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);

    // random frames, starting under a long receiver hold
    hold_req = 1'b1;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      send_random_frame(sent);
      total += sent;
    end

    in_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
